// ===== rtl/core/stit_pkg.sv =====
// ----------------------------------------------------------------------------
// stit_pkg: segment / triangle crossing test, shared types
// Coordinate widths, vector types, outcome codes and small helpers.
// ----------------------------------------------------------------------------
package stit_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FIELD_BITS = 48;
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;       // difference of two coords
  localparam int unsigned CROSS_BITS = 2 * DIFF_BITS + 1;    // cross product component
  localparam int unsigned TRI_BITS   = CROSS_BITS + DIFF_BITS + 2; // dot of three terms

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic signed [TRI_BITS-1:0]   tri_t;
  typedef logic [FIELD_BITS-1:0]        field_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pvec_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } dvec_t;

  typedef struct packed {
    cross_t x;
    cross_t y;
    cross_t z;
  } cvec_t;

  typedef enum logic [1:0] {
    OC_PARALLEL = 2'd0,
    OC_OUTSIDE_SEG = 2'd1,
    OC_OUTSIDE_TRI = 2'd2,
    OC_HIT = 2'd3
  } stit_outcome_e;

  // x in the lowest lane; bits past the field read as zero
  function automatic pvec_t unpack(field_t f);
    logic [3*COORD_BITS+FIELD_BITS-1:0] wide;
    pvec_t r;
    wide = {{(3*COORD_BITS){1'b0}}, f};
    r.x = coord_t'(wide[0*COORD_BITS +: COORD_BITS]);
    r.y = coord_t'(wide[1*COORD_BITS +: COORD_BITS]);
    r.z = coord_t'(wide[2*COORD_BITS +: COORD_BITS]);
    return r;
  endfunction

  function automatic dvec_t vsub(pvec_t a, pvec_t b);
    dvec_t r;
    r.x = diff_t'(a.x) - diff_t'(b.x);
    r.y = diff_t'(a.y) - diff_t'(b.y);
    r.z = diff_t'(a.z) - diff_t'(b.z);
    return r;
  endfunction

  function automatic tri_t vdot(cvec_t c, dvec_t v);
    return tri_t'(c.x) * tri_t'(v.x) + tri_t'(c.y) * tri_t'(v.y)
         + tri_t'(c.z) * tri_t'(v.z);
  endfunction

endpackage

// ===== rtl/core/stit_in_if.sv =====
// ----------------------------------------------------------------------------
// stit_in_if: query channel
// Segment endpoints and triangle corners, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stit_in_if;
  logic                    valid;
  logic                    ready;
  logic [stit_pkg::FIELD_BITS-1:0] seg_start;
  logic [stit_pkg::FIELD_BITS-1:0] seg_end;
  logic [stit_pkg::FIELD_BITS-1:0] corner_a;
  logic [stit_pkg::FIELD_BITS-1:0] corner_b;
  logic [stit_pkg::FIELD_BITS-1:0] corner_c;

  modport source (output valid, seg_start, seg_end, corner_a, corner_b, corner_c,
                  input ready);
  modport sink (input valid, seg_start, seg_end, corner_a, corner_b, corner_c,
                output ready);
endinterface

// ===== rtl/core/stit_out_if.sv =====
// ----------------------------------------------------------------------------
// stit_out_if: result channel
// Hit flag and outcome code, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stit_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] outcome;

  modport source (output valid, hit, outcome, input ready);
  modport sink (input valid, hit, outcome, output ready);
endinterface

// ===== rtl/core/stit_cross.sv =====
// ----------------------------------------------------------------------------
// stit_cross: exact 3D cross product
// Six narrow signed multipliers and three subtracts, combinational.
// ----------------------------------------------------------------------------
module stit_cross (
  input  stit_pkg::dvec_t a_i,
  input  stit_pkg::dvec_t b_i,
  output stit_pkg::cvec_t r_o
);
  import stit_pkg::*;

  always_comb begin
    r_o.x = cross_t'(a_i.y) * cross_t'(b_i.z) - cross_t'(a_i.z) * cross_t'(b_i.y);
    r_o.y = cross_t'(a_i.z) * cross_t'(b_i.x) - cross_t'(a_i.x) * cross_t'(b_i.z);
    r_o.z = cross_t'(a_i.x) * cross_t'(b_i.y) - cross_t'(a_i.y) * cross_t'(b_i.x);
  end

endmodule

// ===== rtl/core/segment_triangle_intersect_top.sv =====
// ----------------------------------------------------------------------------
// segment_triangle_intersect_top: segment / triangle crossing test
// Four-stage pipeline: differences, cross products, dot products, decision.
//
//   channel | dir | words                                  | handshake
//   in_i    | in  | seg_start seg_end corner_a/b/c (48 b)  | valid/ready
//   out_o   | out | hit, outcome (2 b)                     | valid/ready
//
// One word per cycle sustained while out_o is ready; the register stages follow
// the multiply chain: cross product, then triple product.
// Each stage holds its own valid bit and loads when empty or draining, so a
// stalled output only backs up as far as the bubbles allow.
// Reset clears the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module segment_triangle_intersect_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  stit_in_if.sink    in_i,
  stit_out_if.source out_o
);
  import stit_pkg::*;

  // stage enables, back to front
  logic en_out, en3, en2, en1;
  logic v1_q, v2_q, v3_q, vo_q;

  assign en_out = !vo_q || out_o.ready;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign in_i.ready = en1;

  // stage 1: unpack and differences
  pvec_t ps, pe, pa, pb, pc;
  dvec_t ab_d, ac_d, cb_d, sa_d, sb_d, se_d, dd_d;
  dvec_t ab1_q, ac1_q, cb1_q, sa1_q, sb1_q, se1_q, dd1_q;

  always_comb begin
    ps   = unpack(in_i.seg_start);
    pe   = unpack(in_i.seg_end);
    pa   = unpack(in_i.corner_a);
    pb   = unpack(in_i.corner_b);
    pc   = unpack(in_i.corner_c);
    ab_d = vsub(pb, pa);
    ac_d = vsub(pc, pa);
    cb_d = vsub(pc, pb);
    sa_d = vsub(ps, pa);
    sb_d = vsub(ps, pb);
    se_d = vsub(ps, pe);
    dd_d = vsub(pe, ps);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ab1_q <= ab_d;
      ac1_q <= ac_d;
      cb1_q <= cb_d;
      sa1_q <= sa_d;
      sb1_q <= sb_d;
      se1_q <= se_d;
      dd1_q <= dd_d;
    end
  end

  // stage 2: plane normal and (S-corner) x D for the edge tests
  cvec_t n_d, qsa_d, qsb_d;
  cvec_t n2_q, qsa2_q, qsb2_q;
  dvec_t ab2_q, ac2_q, cb2_q, sa2_q, se2_q;

  stit_cross u_cross_n   (.a_i(ab1_q), .b_i(ac1_q), .r_o(n_d));
  stit_cross u_cross_qsa (.a_i(sa1_q), .b_i(dd1_q), .r_o(qsa_d));
  stit_cross u_cross_qsb (.a_i(sb1_q), .b_i(dd1_q), .r_o(qsb_d));

  always_ff @(posedge clk_i) begin
    if (en2) begin
      n2_q   <= n_d;
      qsa2_q <= qsa_d;
      qsb2_q <= qsb_d;
      ab2_q  <= ab1_q;
      ac2_q  <= ac1_q;
      cb2_q  <= cb1_q;
      sa2_q  <= sa1_q;
      se2_q  <= se1_q;
    end
  end

  // stage 3: num, den and the three triple products edge . ((S-v) x D)
  tri_t num_q, den_q, t1_q, t2_q, t3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      num_q <= vdot(n2_q, sa2_q);
      den_q <= vdot(n2_q, se2_q);
      t1_q  <= vdot(qsb2_q, cb2_q);
      t2_q  <= vdot(qsa2_q, ac2_q);
      t3_q  <= vdot(qsa2_q, ab2_q);
    end
  end

  // stage 4: sign logic
  logic signed [TRI_BITS:0] nd_diff;
  logic den_neg, den_zero, den_pos, num_neg, num_pos, nd_neg, nd_pos;
  logic t1_neg, t1_zero, t2_neg, t2_zero, t3_neg, t3_zero, in_tri;
  stit_outcome_e oc_d;
  logic hit_q;
  stit_outcome_e oc_q;

  always_comb begin
    nd_diff  = {num_q[TRI_BITS-1], num_q} - {den_q[TRI_BITS-1], den_q};
    den_neg  = den_q[TRI_BITS-1];
    den_zero = (den_q == '0);
    den_pos  = !den_neg && !den_zero;
    num_neg  = num_q[TRI_BITS-1];
    num_pos  = !num_neg && (num_q != '0);
    nd_neg   = nd_diff[TRI_BITS];
    nd_pos   = !nd_neg && (nd_diff != '0);
    t1_neg   = t1_q[TRI_BITS-1];
    t1_zero  = (t1_q == '0);
    t2_neg   = t2_q[TRI_BITS-1];
    t2_zero  = (t2_q == '0);
    t3_neg   = t3_q[TRI_BITS-1];
    t3_zero  = (t3_q == '0);
    // crossing point against each edge; the expected sign follows den
    if (den_pos) begin
      in_tri = (t1_neg || t1_zero) && !t2_neg && (t3_neg || t3_zero);
    end else begin
      in_tri = !t1_neg && (t2_neg || t2_zero) && !t3_neg;
    end
    if (den_zero) begin
      oc_d = OC_PARALLEL;
    end else if ((num_pos && den_neg) || (num_neg && den_pos) ||
                 (den_pos && nd_pos) || (den_neg && nd_neg)) begin
      oc_d = OC_OUTSIDE_SEG;
    end else if (in_tri) begin
      oc_d = OC_HIT;
    end else begin
      oc_d = OC_OUTSIDE_TRI;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hit_q <= (oc_d == OC_HIT);
      oc_q  <= oc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en_out) vo_q <= v3_q;
    end
  end

  assign out_o.valid   = vo_q;
  assign out_o.hit     = hit_q;
  assign out_o.outcome = oc_q;

endmodule

// ===== tb/sv/segment_triangle_intersect_top_test.sv =====
// ----------------------------------------------------------------------------
// segment_triangle_intersect_top_test: crossing test bench
// Streams segment / triangle queries through the block with bursty input and
// a stalling output, predicts each outcome with exact wide integer math and
// checks every result word in order.
// ----------------------------------------------------------------------------
module segment_triangle_intersect_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stit_pkg::*;

  localparam int unsigned CB = stit_pkg::COORD_BITS;

  typedef logic signed [191:0] acc_t;
  typedef longint vec3_t[3];

  class crossing_scoreboard;
    stit_outcome_e pending_q[$];
    int unsigned   errors;

    static function vec3_t lanes(field_t f);
      logic [3*CB+FIELD_BITS-1:0] wide;
      logic [CB-1:0] raw;
      vec3_t v;
      wide = {{(3*CB){1'b0}}, f};
      for (int k = 0; k < 3; k++) begin
        raw = wide[k*CB +: CB];
        v[k] = longint'(raw);
        if (raw[CB-1]) v[k] -= longint'(1) << CB;
      end
      return v;
    endfunction

    static function vec3_t minus(vec3_t a, vec3_t b);
      vec3_t r;
      for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
      return r;
    endfunction

    static function vec3_t cross3(vec3_t a, vec3_t b);
      vec3_t r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
    endfunction

    static function acc_t dot3(vec3_t a, vec3_t b);
      return acc_t'(a[0]) * acc_t'(b[0]) + acc_t'(a[1]) * acc_t'(b[1])
           + acc_t'(a[2]) * acc_t'(b[2]);
    endfunction

    static function int sgn(acc_t v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // crossing point on the inner side of edge (a,b), ties pass
    static function bit inner_side(vec3_t a, vec3_t b, vec3_t opp, vec3_t s,
                                   vec3_t d, acc_t num, acc_t den);
      vec3_t e, x;
      acc_t lin, slope;
      int sg;
      e = minus(b, a);
      x = cross3(e, minus(opp, a));
      lin = dot3(cross3(e, minus(s, a)), x);
      slope = dot3(cross3(e, d), x);
      sg = sgn(lin * den + num * slope);
      if (den < 0) sg = -sg;
      return sg >= 0;
    endfunction

    static function stit_outcome_e classify(field_t fs, field_t fe, field_t fa,
                                            field_t fb, field_t fc);
      vec3_t s, e, a, b, c, n, d;
      acc_t num, den;
      int sd, sn, sdf;
      s = lanes(fs); e = lanes(fe); a = lanes(fa); b = lanes(fb); c = lanes(fc);
      n = cross3(minus(b, a), minus(c, a));
      d = minus(e, s);
      num = dot3(n, minus(s, a));
      den = dot3(n, minus(s, e));
      sd = sgn(den);
      sn = sgn(num);
      sdf = sgn(num - den);
      if (sd == 0) return OC_PARALLEL;
      if (sn * sd < 0 || (sd > 0 && sdf > 0) || (sd < 0 && sdf < 0))
        return OC_OUTSIDE_SEG;
      if (inner_side(b, c, a, s, d, num, den) && inner_side(a, c, b, s, d, num, den)
          && inner_side(a, b, c, s, d, num, den))
        return OC_HIT;
      return OC_OUTSIDE_TRI;
    endfunction

    function void note_query(field_t fs, field_t fe, field_t fa, field_t fb,
                             field_t fc);
      pending_q.push_back(classify(fs, fe, fa, fb, fc));
    endfunction

    function void check_result(logic hit, logic [1:0] outcome);
      stit_outcome_e exp_oc;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word hit=%b outcome=%0d", $realtime, hit,
                 outcome);
        errors++;
        return;
      end
      exp_oc = pending_q.pop_front();
      if (outcome !== exp_oc) begin
        $display("%0t: outcome expected %0d actual %0d", $realtime, exp_oc, outcome);
        errors++;
      end
      if (hit !== (exp_oc == OC_HIT)) begin
        $display("%0t: hit expected %b actual %b", $realtime, exp_oc == OC_HIT, hit);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stit_in_if  in_i ();
  stit_out_if out_o ();

  segment_triangle_intersect_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o)
  );

  crossing_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  initial begin
    in_i.valid = 1'b0;
    in_i.seg_start = '0;
    in_i.seg_end = '0;
    in_i.corner_a = '0;
    in_i.corner_b = '0;
    in_i.corner_c = '0;
    out_o.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_i.valid && in_i.ready)
        sb.note_query(in_i.seg_start, in_i.seg_end, in_i.corner_a, in_i.corner_b,
                      in_i.corner_c);
      if (out_o.valid && out_o.ready) sb.check_result(out_o.hit, out_o.outcome);
    end
  end

  // receiver stall pattern: a randomly drawn mode sets out_o.ready
  int unsigned stall_cyc = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 48 == 0) stall_mode <= $urandom_range(3, 0);
    case (stall_mode)
      0: out_o.ready <= 1'b1;
      1: out_o.ready <= ($urandom_range(1, 0) == 1);
      2: out_o.ready <= (stall_cyc % 5 < 2);
      default: out_o.ready <= ($urandom_range(7, 0) == 0);
    endcase
  end

  function automatic field_t pk(int x, int y, int z);
    logic [15:0] xs, ys, zs;
    xs = x[15:0]; ys = y[15:0]; zs = z[15:0];
    return {zs, ys, xs};
  endfunction

  function automatic int rnd(int r);
    return int'($urandom_range(2 * r, 0)) - r;
  endfunction

  int unsigned burst_left = 0;

  // called at a rising edge; returns at the accepting edge with valid still high
  task automatic send_query(field_t fs, field_t fe, field_t fa, field_t fb,
                            field_t fc);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_i.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_i.seg_start <= fs;
    in_i.seg_end <= fe;
    in_i.corner_a <= fa;
    in_i.corner_b <= fb;
    in_i.corner_c <= fc;
    in_i.valid <= 1'b1;
    do @(posedge clk_i); while (!in_i.ready);
  endtask

  task automatic send_built();
    int sc, ax, ay, az, bx, by, bz, cx, cy, cz, u, v, px, py, pz, wx, wy, wz, m;
    sc = ($urandom_range(2, 0) == 0) ? 15 : (($urandom_range(1, 0) == 0) ? 255 : 4000);
    ax = rnd(sc); ay = rnd(sc); az = rnd(sc);
    bx = rnd(sc); by = rnd(sc); bz = rnd(sc);
    cx = rnd(sc); cy = rnd(sc); cz = rnd(sc);
    u = $urandom_range(10, 0);
    v = $urandom_range(10 - u, 0);
    px = ax + (u * (bx - ax) + v * (cx - ax)) / 8;
    py = ay + (u * (by - ay) + v * (cy - ay)) / 8;
    pz = az + (u * (bz - az) + v * (cz - az)) / 8;
    wx = rnd(sc); wy = rnd(sc); wz = rnd(sc);
    m = $urandom_range(3, 0);
    if ($urandom_range(5, 0) == 0)
      send_query(pk(px + wx, py + wy, pz + wz), pk(px + 2 * wx, py + 2 * wy, pz + 2 * wz),
                 pk(ax, ay, az), pk(bx, by, bz), pk(cx, cy, cz));
    else
      send_query(pk(px + wx, py + wy, pz + wz), pk(px - m * wx, py - m * wy, pz - m * wz),
                 pk(ax, ay, az), pk(bx, by, bz), pk(cx, cy, cz));
  endtask

  initial begin
    field_t ta, tb, tc;
    int unsigned pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ta = pk(0, 0, 0); tb = pk(16, 0, 0); tc = pk(0, 16, 0);
    send_query(pk(4, 4, -8), pk(4, 4, 8), ta, tb, tc);     // plain hit
    send_query(pk(4, 4, 0), pk(4, 4, 8), ta, tb, tc);      // crosses at start
    send_query(pk(4, 4, 8), pk(4, 4, 0), ta, tb, tc);      // crosses at end
    send_query(pk(8, 0, 8), pk(8, 0, -8), ta, tb, tc);     // on an edge
    send_query(pk(8, 8, 8), pk(8, 8, -8), ta, tb, tc);     // on hypotenuse
    send_query(pk(0, 0, -3), pk(0, 0, 5), ta, tb, tc);     // through a vertex
    send_query(pk(20, 20, -8), pk(20, 20, 8), ta, tb, tc); // outside triangle
    send_query(pk(4, 4, 4), pk(4, 4, 8), ta, tb, tc);      // plane beyond segment
    send_query(pk(4, 4, -8), pk(4, 4, -1), ta, tb, tc);
    send_query(pk(0, 0, 4), pk(9, 3, 4), ta, tb, tc);      // parallel
    send_query(pk(1, 1, 0), pk(3, 2, 0), ta, tb, tc);      // lies in plane
    send_query(pk(4, 4, 2), pk(4, 4, 2), ta, tb, tc);      // zero length
    send_query(pk(4, 4, -8), pk(4, 4, 8), ta, tb, pk(32, 0, 0)); // degenerate
    send_query(pk(4, 4, -8), pk(4, 4, 8), ta, ta, ta);
    send_query('0, '0, '0, '0, '0);
    send_query('1, '1, '1, '1, '1);
    send_query(pk(0, 0, -32768), pk(0, 0, 32767), pk(-32768, -32768, 0),
               pk(32767, -32768, 0), pk(0, 32767, 0));
    send_query(pk(32767, 32767, 32767), pk(-32768, -32768, -32768),
               pk(-32768, 32767, 0), pk(32767, -32768, 0), pk(0, 0, 32767));
    send_query(pk(-32768, 1, -32768), pk(32767, -1, 32767), pk(32767, 32767, -32768),
               pk(-32768, 0, 32767), pk(0, -32768, 0));

    for (int i = 0; i < 550; i++) begin
      pick = $urandom_range(19, 0);
      if (pick < 12) send_built();
      else if (pick < 16)
        send_query(pk(rnd(20), rnd(20), rnd(20)), pk(rnd(20), rnd(20), rnd(20)),
                   pk(rnd(20), rnd(20), rnd(20)), pk(rnd(20), rnd(20), rnd(20)),
                   pk(rnd(20), rnd(20), rnd(20)));
      else
        send_query(field_t'({$urandom, $urandom}), field_t'({$urandom, $urandom}),
                   field_t'({$urandom, $urandom}), field_t'({$urandom, $urandom}),
                   field_t'({$urandom, $urandom}));
    end
    in_i.valid <= 1'b0;

    // let the monitor log the last accepted word first
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
